@@ hw/rtl/fbac_pkg.sv @@
`default_nettype none
package fbac_pkg;

  // Field widths
  localparam int unsigned FLOW_W    = 16;
  localparam int unsigned HOUR_W    = 13;
  localparam int unsigned AMP_W     = 17;
  localparam int unsigned PHASE_W   = 16;
  localparam int unsigned PER_W     = 16;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 3;

  // Dividend is hour scaled by one full turn
  localparam int unsigned DVD_W = HOUR_W + PHASE_W;

  localparam int unsigned SINE_ADDR_BITS = 8;

  localparam logic [PER_W-1:0]  DEF_FIRST_PERIOD  = 16'd6144;
  localparam logic [PER_W-1:0]  DEF_SECOND_PERIOD = 16'd3072;
  localparam logic [FLOW_W-1:0] FLOW_FLOOR  = 16'd128;
  localparam logic [FLOW_W-1:0] LEAK_MARGIN = 16'd64;
  localparam logic [FLOW_W-1:0] OVER_MARGIN = 16'd512;
  localparam logic [HOUR_W-1:0] NIGHT_START = 13'd256;
  localparam logic [HOUR_W-1:0] NIGHT_END   = 13'd1280;

  // Q30 Taylor coefficients of sin(pi/2 x)
  localparam longint unsigned TC1 = 64'd1686629713;
  localparam longint unsigned TC3 = 64'd693598669;
  localparam longint unsigned TC5 = 64'd85569306;
  localparam longint unsigned TC7 = 64'd5026995;
  localparam longint unsigned TC9 = 64'd172273;

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_LEAK    = 2'd1,
    VERDICT_OVERUSE = 2'd2
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAN     = 3'd0,
    REG_AMP1     = 3'd1,
    REG_PHASE1   = 3'd2,
    REG_PERIOD1  = 3'd3,
    REG_AMP2     = 3'd4,
    REG_PHASE2   = 3'd5,
    REG_PERIOD2  = 3'd6,
    REG_SIG_VLD  = 3'd7
  } cfg_reg_e;

  // Quarter-wave sine entry, unsigned Q0.15, evaluated at elaboration
  function automatic logic [14:0] rom_entry(input int unsigned k, input int unsigned abits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    x  = 64'(k) << (16 - abits);
    x2 = (x * x) >> 16;
    p  = TC9;
    p  = TC7 - ((p * x2) >> 16);
    p  = TC5 - ((p * x2) >> 16);
    p  = TC3 - ((p * x2) >> 16);
    p  = TC1 - ((p * x2) >> 16);
    p  = (p * x) >> 16;
    p  = (p + 64'd16384) >> 15;
    if (p > 64'd32767) p = 64'd32767;
    return p[14:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fbac_if.sv @@
`default_nettype none
interface fbac_in_if;
  logic                          valid;
  logic                          ready;
  logic [fbac_pkg::FLOW_W-1:0]   measured_flow;
  logic [fbac_pkg::HOUR_W-1:0]   hour_of_day;
  modport source (output valid, output measured_flow, output hour_of_day, input ready);
  modport sink   (input valid, input measured_flow, input hour_of_day, output ready);
endinterface

interface fbac_out_if;
  logic                          valid;
  logic                          ready;
  fbac_pkg::verdict_e            verdict;
  logic [fbac_pkg::FLOW_W-1:0]   expected_flow;
  modport source (output valid, output verdict, output expected_flow, input ready);
  modport sink   (input valid, input verdict, input expected_flow, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fbac_div.sv @@
`default_nettype none
module fbac_div (
  input  wire logic                          clk_i,
  input  wire logic                          adv_i,
  input  wire logic [fbac_pkg::HOUR_W-1:0]   hour_i,
  input  wire logic [fbac_pkg::PER_W-1:0]    per_i,
  output logic      [fbac_pkg::PHASE_W-1:0]  quo_o
);
  localparam int unsigned STEPS = fbac_pkg::DVD_W;
  localparam int unsigned RW    = fbac_pkg::PER_W;
  localparam int unsigned QW    = fbac_pkg::PHASE_W;

  logic [RW-1:0]    rem_q [STEPS];
  logic [STEPS-1:0] dvd_q [STEPS];
  logic [QW-1:0]    quo_q [STEPS];

  // One restoring step per stage, most significant dividend bit first
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [RW-1:0]    rem_in;
    logic [STEPS-1:0] dvd_in;
    logic [QW-1:0]    quo_in;
    logic [RW:0]      cand;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = {hour_i, {QW{1'b0}}};
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign dvd_in = dvd_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign cand = {rem_in, dvd_in[STEPS-1]};
    assign ge   = cand >= {1'b0, per_i};

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s] <= ge ? RW'(cand - {1'b0, per_i}) : cand[RW-1:0];
        dvd_q[s] <= dvd_in << 1;
        quo_q[s] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[STEPS-1];
endmodule
`default_nettype wire

@@ hw/rtl/fbac_sine.sv @@
`default_nettype none
module fbac_sine #(
  parameter int unsigned SINE_ADDR_BITS = fbac_pkg::SINE_ADDR_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          adv_i,
  input  wire logic [fbac_pkg::PHASE_W-1:0]  quo_i,
  input  wire logic [fbac_pkg::PHASE_W-1:0]  phase_i,
  output logic signed [15:0]                 sine_o
);
  localparam int unsigned FULL = 1 << SINE_ADDR_BITS;
  localparam int unsigned AW   = SINE_ADDR_BITS;

  logic [14:0] rom_w [FULL+1];

  // Quarter-wave table, constant
  for (genvar k = 0; k <= FULL; k++) begin : g_rom
    assign rom_w[k] = fbac_pkg::rom_entry(k, SINE_ADDR_BITS);
  end

  logic [fbac_pkg::PHASE_W-1:0] ang;
  logic [AW-1:0]                addr;
  logic [AW:0]                  k_sel;
  logic [14:0]                  mag;
  logic signed [15:0]           sine_d;

  // Fold angle into the first quadrant and look up
  always_comb begin
    ang    = quo_i + phase_i;
    addr   = ang[13 -: AW];
    k_sel  = ang[14] ? ((AW+1)'(FULL) - {1'b0, addr}) : {1'b0, addr};
    mag    = rom_w[k_sel];
    sine_d = ang[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) sine_o <= sine_d;
  end
endmodule
`default_nettype wire

@@ hw/rtl/flow_baseline_anomaly_classifier.sv @@
// Flow baseline classifier: each request (flow reading, hour of day) yields one result holding
// the predicted flow (mean plus two configured sinusoids, clamped to 0..65535) and a verdict of
// ok, night leak or overuse. One request is taken every cycle while the output is not stalled.
// The 29-stage restoring divider turns hour and period into a sine angle, followed by sine
// lookup, multiply, sum and compare stages. A stalled output holds the whole pipeline.
// Write configuration only while no request is in flight.
`default_nettype none
module flow_baseline_anomaly_classifier #(
  parameter int unsigned SINE_ADDR_BITS = fbac_pkg::SINE_ADDR_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  fbac_in_if.sink                              in_i,
  fbac_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [fbac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fbac_pkg::CFG_W-1:0]      cfg_wdata_i
);
  localparam int unsigned STEPS = fbac_pkg::DVD_W;
  localparam int unsigned FW    = fbac_pkg::FLOW_W;
  localparam int unsigned HW    = fbac_pkg::HOUR_W;
  localparam int unsigned PW    = fbac_pkg::PER_W;

  // Configuration registers
  logic [FW-1:0]        mean_q;
  logic signed [16:0]   amp1_q, amp2_q;
  logic [PW-1:0]        phase1_q, phase2_q, per1_q, per2_q;
  logic                 sig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q   <= '0;
      amp1_q   <= '0;
      phase1_q <= '0;
      per1_q   <= fbac_pkg::DEF_FIRST_PERIOD;
      amp2_q   <= '0;
      phase2_q <= '0;
      per2_q   <= fbac_pkg::DEF_SECOND_PERIOD;
      sig_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (fbac_pkg::cfg_reg_e'(cfg_idx_i))
        fbac_pkg::REG_MEAN:    mean_q   <= cfg_wdata_i[FW-1:0];
        fbac_pkg::REG_AMP1:    amp1_q   <= $signed(cfg_wdata_i);
        fbac_pkg::REG_PHASE1:  phase1_q <= cfg_wdata_i[PW-1:0];
        fbac_pkg::REG_PERIOD1: per1_q   <= (cfg_wdata_i[PW-1:0] == '0) ?
                                           fbac_pkg::DEF_FIRST_PERIOD : cfg_wdata_i[PW-1:0];
        fbac_pkg::REG_AMP2:    amp2_q   <= $signed(cfg_wdata_i);
        fbac_pkg::REG_PHASE2:  phase2_q <= cfg_wdata_i[PW-1:0];
        fbac_pkg::REG_PERIOD2: per2_q   <= (cfg_wdata_i[PW-1:0] == '0) ?
                                           fbac_pkg::DEF_SECOND_PERIOD : cfg_wdata_i[PW-1:0];
        fbac_pkg::REG_SIG_VLD: sig_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the result register is stalled
  logic adv;
  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // Sideband alongside the dividers
  logic          vld_q  [STEPS];
  logic [FW-1:0] flow_q [STEPS];
  logic [HW-1:0] hour_q [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_side
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) vld_q[s] <= 1'b0;
        else if (adv) vld_q[s] <= in_i.valid;
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          flow_q[s] <= in_i.measured_flow;
          hour_q[s] <= in_i.hour_of_day;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) vld_q[s] <= 1'b0;
        else if (adv) vld_q[s] <= vld_q[s-1];
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          flow_q[s] <= flow_q[s-1];
          hour_q[s] <= hour_q[s-1];
        end
      end
    end
  end

  // Angle dividers, one per sinusoid
  logic [PW-1:0] quo1, quo2;

  fbac_div u_div1 (.clk_i, .adv_i(adv), .hour_i(in_i.hour_of_day), .per_i(per1_q), .quo_o(quo1));
  fbac_div u_div2 (.clk_i, .adv_i(adv), .hour_i(in_i.hour_of_day), .per_i(per2_q), .quo_o(quo2));

  // Sine lookup stage
  logic signed [15:0] sin1, sin2;
  logic               a_vld_q;
  logic [FW-1:0]      a_flow_q;
  logic [HW-1:0]      a_hour_q;

  fbac_sine #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_sin1 (
    .clk_i, .adv_i(adv), .quo_i(quo1), .phase_i(phase1_q), .sine_o(sin1));
  fbac_sine #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_sin2 (
    .clk_i, .adv_i(adv), .quo_i(quo2), .phase_i(phase2_q), .sine_o(sin2));

  // Multiply stage
  logic               b_vld_q;
  logic [FW-1:0]      b_flow_q;
  logic [HW-1:0]      b_hour_q;
  logic signed [32:0] prod1_q, prod2_q;

  // Sum and clamp stage
  logic               c_vld_q;
  logic [FW-1:0]      c_flow_q;
  logic               c_night_q;
  logic [FW-1:0]      c_exp_q;

  // Result register
  logic               d_vld_q;
  fbac_pkg::verdict_e d_verdict_q;
  logic [FW-1:0]      d_exp_q;

  logic signed [32:0] rnd1, rnd2;
  logic signed [19:0] sum;
  logic               night;
  logic [FW-1:0]      exp_d;
  logic [FW-1:0]      margin;
  logic [FW:0]        thr;
  fbac_pkg::verdict_e verdict_d;

  always_comb begin
    // Round terms half up to Q8.8 and sum with the mean
    rnd1 = (prod1_q + 33'sd16384) >>> 15;
    rnd2 = (prod2_q + 33'sd16384) >>> 15;
    sum  = $signed({4'b0, mean_q}) + 20'(rnd1) + 20'(rnd2);
    if (sum < 0)               exp_d = '0;
    else if (sum > 20'sd65535) exp_d = '1;
    else                       exp_d = sum[FW-1:0];

    if (fbac_pkg::NIGHT_START <= fbac_pkg::NIGHT_END)
      night = (b_hour_q >= fbac_pkg::NIGHT_START) && (b_hour_q < fbac_pkg::NIGHT_END);
    else
      night = (b_hour_q >= fbac_pkg::NIGHT_START) || (b_hour_q < fbac_pkg::NIGHT_END);

    // Compare reading against expected plus margin
    margin    = c_night_q ? fbac_pkg::LEAK_MARGIN : fbac_pkg::OVER_MARGIN;
    thr       = {1'b0, c_exp_q} + {1'b0, margin};
    verdict_d = fbac_pkg::VERDICT_OK;
    if (sig_q && (c_flow_q >= fbac_pkg::FLOW_FLOOR) && ({1'b0, c_flow_q} > thr))
      verdict_d = c_night_q ? fbac_pkg::VERDICT_LEAK : fbac_pkg::VERDICT_OVERUSE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= vld_q[STEPS-1];
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_flow_q    <= flow_q[STEPS-1];
      a_hour_q    <= hour_q[STEPS-1];
      b_flow_q    <= a_flow_q;
      b_hour_q    <= a_hour_q;
      prod1_q     <= 33'(amp1_q) * 33'(sin1);
      prod2_q     <= 33'(amp2_q) * 33'(sin2);
      c_flow_q    <= b_flow_q;
      c_night_q   <= night;
      c_exp_q     <= exp_d;
      d_verdict_q <= verdict_d;
      d_exp_q     <= c_exp_q;
    end
  end

  assign out_o.valid         = d_vld_q;
  assign out_o.verdict       = d_verdict_q;
  assign out_o.expected_flow = d_exp_q;
endmodule
`default_nettype wire

@@ hw/rtl/fbac_checker.sv @@
`default_nettype none
module fbac_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  verdict_i,
  input wire logic [15:0] expected_flow_i
);
  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // With no result pending the block takes requests
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // Verdict stays in its defined range
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (verdict_i != 2'd3))
    else $error("undefined verdict");

  // An anomaly needs headroom above the expected flow
  a_anomaly_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (verdict_i != fbac_pkg::VERDICT_OK) |-> (expected_flow_i != 16'hFFFF))
    else $error("anomaly at saturated expected flow");
endmodule

bind flow_baseline_anomaly_classifier fbac_checker u_fbac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .verdict_i       (out_o.verdict),
  .expected_flow_i (out_o.expected_flow)
);
`default_nettype wire
